// File: rtl/multi_pool_block_allocator_macros.svh
// Assertion macros for the multi-pool block allocator.
// Included by the top level; no other dependencies.
`ifndef MULTI_POOL_BLOCK_ALLOCATOR_MACROS_SVH
`define MULTI_POOL_BLOCK_ALLOCATOR_MACROS_SVH
`define MPBA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define MPBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// File: rtl/mpba_pkg.sv
// Package for the multi-pool block allocator: sizes, codes and shared structs.
// No dependencies.
`default_nettype none
package mpba_pkg;
    localparam int MAX_POOLS = 8;
    localparam int SLOTS_MAX = 128;
    localparam int RW = $clog2(MAX_POOLS);
    localparam int SW = $clog2(SLOTS_MAX);
    localparam int CW = $clog2(SLOTS_MAX + 1);
    localparam int PW = $clog2(MAX_POOLS + 1);
    localparam int HW = 10;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;
    localparam logic OP_ALLOC = 1'b0;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic link_step;
        logic open_pool;
        logic pop;
        logic push;
        logic remove_step;
        logic done;
    } mpba_cmd_t;

    typedef struct packed {
        logic is_free;
        logic scan_hit;
        logic scan_end;
        logic can_open;
        logic link_last;
        logic free_bad;
        logic free_empties;
        logic remove_end;
    } mpba_stat_t;
endpackage
`default_nettype wire

// File: rtl/mpba_ctrl.sv
// Controller state machine of the multi-pool block allocator.
// Depends on mpba_pkg.
`default_nettype none
module mpba_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mpba_pkg::mpba_stat_t st,
    output mpba_pkg::mpba_cmd_t     cmd
);
    import mpba_pkg::*;
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_DEC = 7'b0000010, S_SCAN = 7'b0000100,
        S_LINK = 7'b0001000, S_POP = 7'b0010000, S_FREE = 7'b0100000,
        S_REM = 7'b1000000
    } state_t;
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = st.is_free ? S_FREE : S_SCAN;
            end
            S_SCAN:
            begin
                if (st.scan_hit)
                begin
                    state_next = S_POP;
                end
                else if (st.scan_end)
                begin
                    if (st.can_open)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        cmd.done = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_LINK:
            begin
                cmd.link_step = 1'b1;
                if (st.link_last)
                begin
                    cmd.open_pool = 1'b1;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                cmd.done = 1'b1;
                state_next = S_IDLE;
            end
            S_FREE:
            begin
                if (st.free_bad)
                begin
                    cmd.done = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.push = 1'b1;
                    if (st.free_empties)
                    begin
                        state_next = S_REM;
                    end
                    else
                    begin
                        cmd.done = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_REM:
            begin
                cmd.remove_step = 1'b1;
                if (st.remove_end)
                begin
                    cmd.done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

// File: rtl/mpba_dp.sv
// Datapath of the multi-pool block allocator: tables, link memory, results.
// Depends on mpba_pkg.
`default_nettype none
module mpba_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                op,
    input  wire logic [9:0]          handle_in,
    input  wire logic [7:0]          cfg_data,
    input  wire logic                cfg_we,
    input  wire mpba_pkg::mpba_cmd_t cmd,
    output mpba_pkg::mpba_stat_t     st,
    output logic                     done,
    output logic [9:0]               handle_out,
    output logic [1:0]               status,
    output logic                     pool_created,
    output logic                     pool_released
);
    import mpba_pkg::*;
    logic [7:0] spp_reg;
    logic [CW-1:0] n_eff;
    logic op_reg;
    logic [HW-1:0] hin_reg;
    logic [RW-1:0] order_reg [MAX_POOLS];
    logic [PW-1:0] active_reg;
    logic [MAX_POOLS-1:0] ractive_reg;
    logic [CW-1:0] used_reg [MAX_POOLS];
    logic [SW-1:0] head_reg [MAX_POOLS];
    logic [SW-1:0] link_mem [MAX_POOLS*SLOTS_MAX];
    logic [SW-1:0] link_rd_reg;
    logic [PW-1:0] k_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] i_reg;
    logic rd_pend_reg;
    logic [RW-1:0] free_r;
    logic [SW-1:0] free_s;
    logic [RW-1:0] low_free;
    logic any_free;
    logic [RW-1:0] scan_r;
    logic [RW-1:0] rd_r;
    logic created_reg;
    logic [CW-1:0] used_dec;

    always_comb
    begin
        n_eff = CW'(spp_reg);
        if (spp_reg == 8'd0) n_eff = CW'(1);
        if (spp_reg > 8'(SLOTS_MAX)) n_eff = CW'(SLOTS_MAX);
    end

    assign free_r = hin_reg[SW +: RW];
    assign free_s = hin_reg[SW-1:0];
    assign scan_r = order_reg[k_reg[RW-1:0]];
    assign rd_r = st.scan_hit ? scan_r : r_reg;

    always_comb
    begin
        low_free = '0;
        any_free = 1'b0;
        for (int r = MAX_POOLS - 1; r >= 0; r--)
        begin
            if (!ractive_reg[r])
            begin
                low_free = RW'(r);
                any_free = 1'b1;
            end
        end
    end

    assign used_dec = (used_reg[free_r] > '0) ? used_reg[free_r] - CW'(1) : '0;

    always_comb
    begin
        st = '0;
        st.is_free = op_reg != OP_ALLOC;
        st.scan_end = (k_reg >= active_reg);
        st.scan_hit = !st.scan_end && (used_reg[scan_r] < n_eff);
        st.can_open = any_free && (active_reg < PW'(MAX_POOLS));
        st.link_last = (i_reg + CW'(1) >= n_eff);
        st.free_bad = (32'(hin_reg >> SW) >= MAX_POOLS) || !ractive_reg[free_r]
                      || (CW'(free_s) >= n_eff);
        st.free_empties = (used_dec == '0);
        st.remove_end = (k_reg + PW'(1) >= active_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.link_step)
        begin
            link_mem[{r_reg, i_reg[SW-1:0]}] <= st.link_last ? '0 : SW'(i_reg + CW'(1));
        end
        else if (cmd.push)
        begin
            link_mem[{free_r, free_s}] <= head_reg[free_r];
        end
        link_rd_reg <= link_mem[{rd_r, head_reg[rd_r]}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg <= 8'd80;
            active_reg <= '0;
            ractive_reg <= '0;
            done <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            done <= cmd.done;
            rd_pend_reg <= cmd.remove_step
                           && (rd_pend_reg || order_reg[k_reg[RW-1:0]] == free_r);
            if (cfg_we) spp_reg <= cfg_data;
            if (cmd.load)
            begin
                op_reg <= op;
                hin_reg <= handle_in;
                k_reg <= '0;
                i_reg <= '0;
                created_reg <= 1'b0;
            end
            if (cmd.scan_step) k_reg <= k_reg + PW'(1);
            if (st.scan_hit && !cmd.load) r_reg <= scan_r;
            if (st.scan_end && !st.scan_hit && !cmd.link_step && !cmd.pop)
                r_reg <= low_free;
            if (cmd.link_step) i_reg <= i_reg + CW'(1);
            if (cmd.open_pool)
            begin
                ractive_reg[r_reg] <= 1'b1;
                used_reg[r_reg] <= '0;
                head_reg[r_reg] <= '0;
                order_reg[active_reg[RW-1:0]] <= r_reg;
                active_reg <= active_reg + PW'(1);
                created_reg <= 1'b1;
            end
            if (cmd.pop)
            begin
                // The link read was issued from the head in the prior cycle.
                head_reg[r_reg] <= (created_reg || cmd.open_pool) ?
                    ((n_eff > CW'(1)) ? SW'(1) : '0) : link_rd_reg;
                used_reg[r_reg] <= used_reg[r_reg] + CW'(1);
                handle_out <= HW'({r_reg, head_reg[r_reg]});
                status <= ST_OK;
                pool_created <= created_reg;
                pool_released <= 1'b0;
            end
            if (cmd.done && !cmd.pop && !cmd.push && !cmd.remove_step)
            begin
                handle_out <= '0;
                pool_released <= 1'b0;
                pool_created <= 1'b0;
                status <= st.is_free ? ST_BAD : ST_FULL;
            end
            if (cmd.push)
            begin
                head_reg[free_r] <= free_s;
                used_reg[free_r] <= used_dec;
                handle_out <= '0;
                status <= ST_OK;
                pool_created <= 1'b0;
                pool_released <= st.free_empties;
                if (st.free_empties)
                begin
                    ractive_reg[free_r] <= 1'b0;
                end
                k_reg <= '0;
            end
            if (cmd.remove_step)
            begin
                if ((rd_pend_reg || order_reg[k_reg[RW-1:0]] == free_r) && !st.remove_end)
                    order_reg[k_reg[RW-1:0]] <= order_reg[RW'(k_reg + PW'(1))];
                if (st.remove_end) active_reg <= active_reg - PW'(1);
                k_reg <= k_reg + PW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/multi_pool_block_allocator.sv
// Top level of the multi-pool block allocator: controller plus datapath.
// Depends on mpba_pkg, mpba_ctrl, mpba_dp and the assertion macro header.
//
// Channel   Signals                          Handshake
// request   start, busy, op, handle_in       start && !busy
// result    done, handle_out, status, flags  one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_data   valid && ready
//
// An allocate decodes, scans the active pools in order and pops a block from the first pool
// with room; failing that it opens a new pool, links its slots and pops, or reports full.
// A free checks the handle and pushes the block, then drops a released pool from the order.
// Reset clears the pool and region flags; no clearing pass is needed.
// The result strobe cannot be stalled; the next request is taken once busy falls.
`default_nettype none
`include "multi_pool_block_allocator_macros.svh"
module multi_pool_block_allocator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       op,
    input  wire logic [9:0] handle_in,
    output logic            done,
    output logic [9:0]      handle_out,
    output logic [1:0]      status,
    output logic            pool_created,
    output logic            pool_released,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);
    import mpba_pkg::*;
    mpba_cmd_t cmd;
    mpba_stat_t st;

    assign cfg_ready = 1'b1;

    mpba_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .st(st), .cmd(cmd));

    mpba_dp u_dp (.clk(clk), .rst_n(rst_n), .op(op), .handle_in(handle_in),
        .cfg_data(cfg_data), .cfg_we(cfg_valid && cfg_ready), .cmd(cmd), .st(st),
        .done(done), .handle_out(handle_out), .status(status),
        .pool_created(pool_created), .pool_released(pool_released));

    `MPBA_ASSERT_NEXT(a_done_after_cmd, cmd.done, done)
    `MPBA_ASSERT_IMPL(a_flags_excl, done, !(pool_created && pool_released))
    `MPBA_ASSERT_IMPL(a_err_zero, done && status != ST_OK, handle_out == '0)
endmodule
`default_nettype wire
